// File: rtl/bpr_pkg.sv
`timescale 1ns / 1ps

package bpr_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int COLOR_W       = 24;
   localparam int DIV_STEPS     = 32;
   localparam int NUM_CH        = 3;

   localparam logic [8:0] PAL_DEPTH_LIMIT = 9'(PALETTE_DEPTH);

   // channel slots, matching the packing of a 24-bit color
   localparam int CH_RED   = 2;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 0;

   localparam logic [2:0] FMT_1BPP  = 3'd0;
   localparam logic [2:0] FMT_4BPP  = 3'd1;
   localparam logic [2:0] FMT_8BPP  = 3'd2;
   localparam logic [2:0] FMT_16BPP = 3'd3;
   localparam logic [2:0] FMT_24BPP = 3'd4;
   localparam logic [2:0] FMT_32BPP = 3'd5;

   localparam logic FUNC_CONVERT = 1'b0;
   localparam logic FUNC_PALETTE = 1'b1;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_MASK      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MASK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_MASK     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL_LIMIT     = 3'd4;

   localparam logic [2:0]  RST_PIXEL_FORMAT  = FMT_32BPP;
   localparam logic [31:0] RST_RED_MASK      = 32'h00FF_0000;
   localparam logic [31:0] RST_GREEN_MASK    = 32'h0000_FF00;
   localparam logic [31:0] RST_BLUE_MASK     = 32'h0000_00FF;
   localparam logic [8:0]  RST_PAL_LIMIT     = 9'd256;

   localparam logic [7:0] NIBBLE_MASK = 8'h0F;

   typedef struct packed {
      logic [4:0]  shift;
      logic [31:0] top;
      logic        zero;
   } chan_cfg_type;

   typedef struct packed {
      logic        valid;
      logic        func;
      logic [31:0] pixel_bits;
      logic [2:0]  pixel_pos;
      logic [7:0]  entry_index;
      logic [23:0] entry_color;
   } in_type;

   typedef struct packed {
      logic                          valid;
      logic                          rsp;
      logic                          scaled;
      logic                          pal_sel;
      logic [COLOR_W-1:0]            rgb;
      logic [NUM_CH-1:0][31:0]       value;
   } front_type;

   typedef struct packed {
      logic                          valid;
      logic                          rsp;
      logic                          scaled;
      logic [COLOR_W-1:0]            rgb;
      logic [NUM_CH-1:0][63:0]       acc;
   } stage_type;

   typedef struct packed {
      logic               valid;
      logic [COLOR_W-1:0] rgb;
   } result_type;

   function automatic logic [7:0] pick_index(input logic [7:0] pix_byte,
                                             input logic [2:0] pos,
                                             input logic [2:0] fmt);
      logic [7:0] idx;
      if (fmt == FMT_8BPP) begin
         idx = pix_byte;
      end else if (fmt == FMT_4BPP) begin
         idx = pos[0] ? (pix_byte & NIBBLE_MASK) : (pix_byte >> 4);
      end else begin
         idx = (pix_byte >> (3'd7 - pos)) & 8'd1;
      end
      return idx;
   endfunction

   // one restoring step: upper word is the remainder, lower collects quotient bits
   function automatic logic [63:0] div_step(input logic [63:0] acc,
                                            input logic [31:0] top);
      logic [64:0] sh;
      logic [32:0] hi;
      logic [32:0] diff;
      logic        qbit;
      sh   = {acc, 1'b0};
      hi   = sh[64:32];
      diff = hi - {1'b0, top};
      qbit = (hi >= {1'b0, top});
      return {(qbit ? diff[31:0] : hi[31:0]), sh[31:1], qbit};
   endfunction

endpackage

// File: rtl/bpr_palette.sv
`timescale 1ns / 1ps

module bpr_palette #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 24,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bpr_mask_prep.sv
`timescale 1ns / 1ps

module bpr_mask_prep (
   input  logic                  clock,
   input  logic [31:0]           mask,
   output bpr_pkg::chan_cfg_type cfg
);

   logic [31:0] lowbit;
   logic [4:0]  shift_in;
   logic [4:0]  shift_ff;
   logic        zero_in;
   logic        zero_ff;
   logic [31:0] run;
   logic [32:0] run_ext;
   logic [31:0] top_in;
   logic [31:0] top_ff;

   always_comb begin
      lowbit   = mask & (~mask + 32'd1);
      shift_in = '0;
      for (int i = 0; i < 32; i++) begin
         if (lowbit[i]) begin
            shift_in = shift_in | 5'(i);
         end
      end
      zero_in = (mask == '0);
      // isolate the run of ones at the bottom, 33 bits so a full mask gives all ones
      run     = mask >> shift_ff;
      run_ext = {1'b0, run} ^ ({1'b0, run} + 33'd1);
      top_in  = run_ext[32:1];
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      zero_ff  <= zero_in;
      top_ff   <= top_in;
   end

   assign cfg.shift = shift_ff;
   assign cfg.top   = top_ff;
   assign cfg.zero  = zero_ff;

endmodule

// File: rtl/bpr_front.sv
`timescale 1ns / 1ps

module bpr_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      req_valid,
   input  logic                                      req_func,
   input  logic [31:0]                               req_pixel_bits,
   input  logic [2:0]                                req_pixel_pos,
   input  logic [7:0]                                req_entry_index,
   input  logic [23:0]                               req_entry_color,
   input  logic [2:0]                                pixel_format,
   input  logic [8:0]                                pal_limit,
   input  logic [bpr_pkg::NUM_CH-1:0][31:0]          masks,
   input  bpr_pkg::chan_cfg_type [bpr_pkg::NUM_CH-1:0] chan_cfg,
   output bpr_pkg::stage_type                        stage_out
);

   bpr_pkg::in_type    in_in;
   bpr_pkg::in_type    in_ff;
   bpr_pkg::front_type front_in;
   bpr_pkg::front_type front_ff;
   bpr_pkg::stage_type stage_in;
   bpr_pkg::stage_type stage_ff;

   logic [7:0]  idx;
   logic        indexed;
   logic        rd_ok;
   logic        wr_ok;
   logic        wr_en;
   logic [31:0] pix_used;
   logic [bpr_pkg::COLOR_W-1:0] rd_data;
   logic [31:0] num;

   always_comb begin
      in_in.valid       = req_valid;
      in_in.func        = req_func;
      in_in.pixel_bits  = req_pixel_bits;
      in_in.pixel_pos   = req_pixel_pos;
      in_in.entry_index = req_entry_index;
      in_in.entry_color = req_entry_color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else if (en) begin
         in_ff <= in_in;
      end
   end

   always_comb begin
      idx     = bpr_pkg::pick_index(in_ff.pixel_bits[7:0], in_ff.pixel_pos, pixel_format);
      indexed = (pixel_format == bpr_pkg::FMT_1BPP) || (pixel_format == bpr_pkg::FMT_4BPP)
                || (pixel_format == bpr_pkg::FMT_8BPP);
      rd_ok   = ({1'b0, idx} < pal_limit) && ({1'b0, idx} < bpr_pkg::PAL_DEPTH_LIMIT);
      wr_ok   = ({1'b0, in_ff.entry_index} < bpr_pkg::PAL_DEPTH_LIMIT);
      wr_en   = en && in_ff.valid && (in_ff.func == bpr_pkg::FUNC_PALETTE) && wr_ok;
      pix_used = (pixel_format == bpr_pkg::FMT_16BPP) ? {16'd0, in_ff.pixel_bits[15:0]}
                                                       : in_ff.pixel_bits;

      front_in.valid   = in_ff.valid;
      front_in.rsp     = (in_ff.func == bpr_pkg::FUNC_CONVERT);
      front_in.scaled  = (pixel_format == bpr_pkg::FMT_16BPP)
                         || (pixel_format == bpr_pkg::FMT_32BPP);
      front_in.pal_sel = indexed && rd_ok;
      front_in.rgb     = (pixel_format == bpr_pkg::FMT_24BPP) ? in_ff.pixel_bits[23:0]
                                                               : '0;
      for (int c = 0; c < bpr_pkg::NUM_CH; c++) begin
         front_in.value[c] = (pix_used & masks[c]) >> chan_cfg[c].shift;
      end
   end

   bpr_palette #(
      .DEPTH (bpr_pkg::PALETTE_DEPTH),
      .WIDTH (bpr_pkg::COLOR_W),
      .AW    (bpr_pkg::PAL_AW)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (in_ff.entry_index[bpr_pkg::PAL_AW-1:0]),
      .wr_data (in_ff.entry_color),
      .rd_en   (en),
      .rd_addr (idx[bpr_pkg::PAL_AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (en) begin
         front_ff <= front_in;
      end
   end

   // value*255 + max/2, wrapping at 32 bits
   always_comb begin
      num            = '0;
      stage_in.valid  = front_ff.valid;
      stage_in.rsp    = front_ff.rsp;
      stage_in.scaled = front_ff.scaled;
      stage_in.rgb    = front_ff.pal_sel ? rd_data : front_ff.rgb;
      for (int c = 0; c < bpr_pkg::NUM_CH; c++) begin
         num = (front_ff.value[c] << 8) - front_ff.value[c] + (chan_cfg[c].top >> 1);
         stage_in.acc[c] = {32'd0, num};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: rtl/bpr_div_stage.sv
`timescale 1ns / 1ps

module bpr_div_stage (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        en,
   input  bpr_pkg::chan_cfg_type [bpr_pkg::NUM_CH-1:0] chan_cfg,
   input  bpr_pkg::stage_type                          d,
   output bpr_pkg::stage_type                          q
);

   bpr_pkg::stage_type stage_in;
   bpr_pkg::stage_type stage_ff;

   always_comb begin
      stage_in = d;
      for (int c = 0; c < bpr_pkg::NUM_CH; c++) begin
         stage_in.acc[c] = bpr_pkg::div_step(d.acc[c], chan_cfg[c].top);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign q = stage_ff;

endmodule

// File: rtl/bpr_out_buf.sv
`timescale 1ns / 1ps

module bpr_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  bpr_pkg::result_type push,
   output logic                en,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue
);

   logic                        out_valid_in;
   logic                        out_valid_ff;
   logic [bpr_pkg::COLOR_W-1:0] out_data_in;
   logic [bpr_pkg::COLOR_W-1:0] out_data_ff;
   logic                        skid_valid_in;
   logic                        skid_valid_ff;
   logic [bpr_pkg::COLOR_W-1:0] skid_data_in;
   logic [bpr_pkg::COLOR_W-1:0] skid_data_ff;
   logic                        push_go;

   assign en      = !skid_valid_ff;
   assign push_go = push.valid && en;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push_go;
            out_data_in  = push.rgb;
         end
      end else if (push_go) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push.rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_red   = out_data_ff[23:16];
   assign rsp_green = out_data_ff[15:8];
   assign rsp_blue  = out_data_ff[7:0];

endmodule

// File: rtl/bitmap_pixel_to_rgb_converter_top.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// req      req_valid/req_ready    func, pixel_bits, pixel_pos, entry_index, entry_color
// rsp      rsp_valid/rsp_ready    red, green, blue
// csr      csr_valid/csr_ready    csr_index, csr_data
//
// One item per clock while req_ready is high. A conversion reaches rsp_valid through the front registers,
// the 32-step restoring divider pipeline that every transfer passes through, and the output register.
// Palette writes travel the same pipeline and give no rsp transfer.
// A stalled rsp fills a one-entry skid; req_ready drops only while it is full.
// Synchronous reset clears valid bits and sets CSR defaults; palette contents are not cleared.
// Mask-derived shift is registered from the mask register, and max is registered from both.

module bitmap_pixel_to_rgb_converter_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic [31:0]                     req_pixel_bits,
   input  logic [2:0]                      req_pixel_pos,
   input  logic [7:0]                      req_entry_index,
   input  logic [23:0]                     req_entry_color,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_red,
   output logic [7:0]                      rsp_green,
   output logic [7:0]                      rsp_blue,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bpr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_data
);

   logic [2:0]                          pixel_format_ff;
   logic [2:0]                          pixel_format_in;
   logic [8:0]                          pal_limit_ff;
   logic [8:0]                          pal_limit_in;
   logic [bpr_pkg::NUM_CH-1:0][31:0]    masks_ff;
   logic [bpr_pkg::NUM_CH-1:0][31:0]    masks_in;
   bpr_pkg::chan_cfg_type [bpr_pkg::NUM_CH-1:0] chan_cfg;
   bpr_pkg::stage_type                  pipe [0:bpr_pkg::DIV_STEPS];
   bpr_pkg::stage_type                  last;
   bpr_pkg::result_type                 result;
   logic [bpr_pkg::NUM_CH-1:0][7:0]     scaled_rgb;
   logic                                en;

   assign csr_ready = 1'b1;
   assign req_ready = en;

   always_comb begin
      pixel_format_in = pixel_format_ff;
      pal_limit_in    = pal_limit_ff;
      masks_in        = masks_ff;
      if (csr_valid) begin
         case (csr_index)
            bpr_pkg::CSR_PIXEL_FORMAT:  pixel_format_in = csr_data[2:0];
            bpr_pkg::CSR_RED_MASK:      masks_in[bpr_pkg::CH_RED] = csr_data;
            bpr_pkg::CSR_GREEN_MASK:    masks_in[bpr_pkg::CH_GREEN] = csr_data;
            bpr_pkg::CSR_BLUE_MASK:     masks_in[bpr_pkg::CH_BLUE] = csr_data;
            bpr_pkg::CSR_PAL_LIMIT:     pal_limit_in = csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff                <= bpr_pkg::RST_PIXEL_FORMAT;
         pal_limit_ff                   <= bpr_pkg::RST_PAL_LIMIT;
         masks_ff[bpr_pkg::CH_RED]      <= bpr_pkg::RST_RED_MASK;
         masks_ff[bpr_pkg::CH_GREEN]    <= bpr_pkg::RST_GREEN_MASK;
         masks_ff[bpr_pkg::CH_BLUE]     <= bpr_pkg::RST_BLUE_MASK;
      end else begin
         pixel_format_ff <= pixel_format_in;
         pal_limit_ff    <= pal_limit_in;
         masks_ff        <= masks_in;
      end
   end

   for (genvar c = 0; c < bpr_pkg::NUM_CH; c++) begin : g_prep
      bpr_mask_prep u_prep (
         .clock (clock),
         .mask  (masks_ff[c]),
         .cfg   (chan_cfg[c])
      );
   end

   bpr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .req_valid       (req_valid),
      .req_func        (req_func),
      .req_pixel_bits  (req_pixel_bits),
      .req_pixel_pos   (req_pixel_pos),
      .req_entry_index (req_entry_index),
      .req_entry_color (req_entry_color),
      .pixel_format    (pixel_format_ff),
      .pal_limit       (pal_limit_ff),
      .masks           (masks_ff),
      .chan_cfg        (chan_cfg),
      .stage_out       (pipe[0])
   );

   for (genvar i = 0; i < bpr_pkg::DIV_STEPS; i++) begin : g_div
      bpr_div_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .chan_cfg (chan_cfg),
         .d        (pipe[i]),
         .q        (pipe[i+1])
      );
   end

   assign last = pipe[bpr_pkg::DIV_STEPS];

   // zero mask forces the scaled channel to zero
   always_comb begin
      for (int c = 0; c < bpr_pkg::NUM_CH; c++) begin
         scaled_rgb[c] = chan_cfg[c].zero ? 8'd0 : last.acc[c][7:0];
      end
      result.valid = last.valid && last.rsp;
      result.rgb   = last.scaled ? scaled_rgb : last.rgb;
   end

   bpr_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (result),
      .en        (en),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

endmodule

// File: sim/bitmap_pixel_to_rgb_converter_top_test.sv
`timescale 1ns / 1ps

module bitmap_pixel_to_rgb_converter_top_test;

   localparam int PIPE_LATENCY   = 36;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 150;

   localparam logic [31:0] DEF_RED_MASK   = bpr_pkg::RST_RED_MASK;
   localparam logic [31:0] DEF_GREEN_MASK = bpr_pkg::RST_GREEN_MASK;
   localparam logic [31:0] DEF_BLUE_MASK  = bpr_pkg::RST_BLUE_MASK;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_rgb_type;

   logic                          clock;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic                          req_func        = bpr_pkg::FUNC_CONVERT;
   logic [31:0]                   req_pixel_bits  = '0;
   logic [2:0]                    req_pixel_pos   = '0;
   logic [7:0]                    req_entry_index = '0;
   logic [23:0]                   req_entry_color = '0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic [7:0]                    rsp_red;
   logic [7:0]                    rsp_green;
   logic [7:0]                    rsp_blue;
   logic                          csr_valid       = 1'b0;
   logic                          csr_ready;
   logic [bpr_pkg::CSR_IDX_W-1:0] csr_index       = bpr_pkg::CSR_PIXEL_FORMAT;
   logic [31:0]                   csr_data        = '0;

   // shadow of the converter settings and palette
   logic [2:0]  fmt_q      = bpr_pkg::RST_PIXEL_FORMAT;
   logic [31:0] red_msk    = bpr_pkg::RST_RED_MASK;
   logic [31:0] green_msk  = bpr_pkg::RST_GREEN_MASK;
   logic [31:0] blue_msk   = bpr_pkg::RST_BLUE_MASK;
   logic [8:0]  pal_count  = bpr_pkg::RST_PAL_LIMIT;
   logic [23:0] palette [bpr_pkg::PALETTE_DEPTH];
   logic        loaded  [bpr_pkg::PALETTE_DEPTH];

   pixel_rgb_type pending_rgb[$];

   logic steady   = 1'b0;
   logic rsp_hold = 1'b0;
   int   mismatch_count = 0;
   int   idle_cycles    = 0;
   int   conversions    = 0;
   int   palette_loads  = 0;
   int   settings       = 0;

   bitmap_pixel_to_rgb_converter_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_pixel_bits  (req_pixel_bits),
      .req_pixel_pos   (req_pixel_pos),
      .req_entry_index (req_entry_index),
      .req_entry_color (req_entry_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [7:0] palette_index(input logic [7:0] pix_byte,
                                                input logic [2:0] pos);
      if (fmt_q == bpr_pkg::FMT_8BPP) return pix_byte;
      if (fmt_q == bpr_pkg::FMT_4BPP) begin
         return pos[0] ? {4'h0, pix_byte[3:0]} : {4'h0, pix_byte[7:4]};
      end
      return {7'h0, pix_byte[3'd7 - pos]};
   endfunction

   function automatic logic [7:0] scale_channel(input logic [31:0] pix,
                                                input logic [31:0] mask);
      int unsigned sh;
      int unsigned w;
      logic [31:0] t;
      logic [31:0] v;
      logic [31:0] top;
      logic [31:0] num;
      if (mask == 32'h0) return 8'h0;
      sh = 0;
      while (!mask[sh]) sh++;
      t = mask >> sh;
      w = 0;
      while (t[0]) begin
         w++;
         t = t >> 1;
      end
      v   = (pix & mask) >> sh;
      top = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
      num = v * 32'd255 + (top >> 1);
      return 8'(num / top);
   endfunction

   function automatic pixel_rgb_type expected_rgb(input logic [31:0] pix,
                                                  input logic [2:0] pos);
      pixel_rgb_type c;
      logic [7:0] idx;
      logic [31:0] p;
      c = '0;
      case (fmt_q)
         bpr_pkg::FMT_1BPP, bpr_pkg::FMT_4BPP, bpr_pkg::FMT_8BPP: begin
            idx = palette_index(pix[7:0], pos);
            if ({1'b0, idx} < pal_count) c = palette[idx];
         end
         bpr_pkg::FMT_24BPP: c = pix[23:0];
         bpr_pkg::FMT_16BPP, bpr_pkg::FMT_32BPP: begin
            p = (fmt_q == bpr_pkg::FMT_16BPP) ? {16'h0, pix[15:0]} : pix;
            c.red   = scale_channel(p, red_msk);
            c.green = scale_channel(p, green_msk);
            c.blue  = scale_channel(p, blue_msk);
         end
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [31:0] random_mask();
      int unsigned w;
      int unsigned sh;
      logic [63:0] run;
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2, 3, 4, 5: begin
            w   = $urandom_range(1, 32);
            sh  = $urandom_range(0, 32 - w);
            run = ((64'd1 << w) - 64'd1) << sh;
            return run[31:0];
         end
         6, 7: return 32'($urandom);
         default: begin
            w   = $urandom_range(1, 8);
            sh  = $urandom_range(0, 16 - w);
            run = ((64'd1 << w) - 64'd1) << sh;
            return run[31:0];
         end
      endcase
   endfunction

   // payload stays up after the transfer; a later call may lower valid while idling, and quiesce lowers it
   task automatic push_item(input logic func, input logic [31:0] pix, input logic [2:0] pos,
                            input logic [7:0] eidx, input logic [23:0] ecolor);
      while (!steady && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_pixel_bits  <= pix;
      req_pixel_pos   <= pos;
      req_entry_index <= eidx;
      req_entry_color <= ecolor;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (func == bpr_pkg::FUNC_PALETTE) begin
         palette[eidx] = ecolor;
         loaded[eidx]  = 1'b1;
         palette_loads++;
      end else begin
         pending_rgb.push_back(expected_rgb(pix, pos));
         conversions++;
      end
   endtask

   // in an indexed format, loads the looked-up palette entry first when it is below the limit and never written
   task automatic send_pixel(input logic [31:0] pix, input logic [2:0] pos);
      logic [7:0] idx;
      idx = palette_index(pix[7:0], pos);
      if (fmt_q <= bpr_pkg::FMT_8BPP && {1'b0, idx} < pal_count && !loaded[idx])
         push_item(bpr_pkg::FUNC_PALETTE, $urandom, 3'($urandom), idx, 24'($urandom));
      push_item(bpr_pkg::FUNC_CONVERT, pix, pos, 8'($urandom), 24'($urandom));
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bpr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         bpr_pkg::CSR_PIXEL_FORMAT: fmt_q     = data[2:0];
         bpr_pkg::CSR_RED_MASK:     red_msk   = data;
         bpr_pkg::CSR_GREEN_MASK:   green_msk = data;
         bpr_pkg::CSR_BLUE_MASK:    blue_msk  = data;
         bpr_pkg::CSR_PAL_LIMIT:    pal_count = data[8:0];
         default: ;
      endcase
   endtask

   task automatic set_mode(input logic [2:0] fmt, input logic [31:0] rm, input logic [31:0] gm,
                           input logic [31:0] bm, input logic [8:0] cnt);
      quiesce();
      write_reg(bpr_pkg::CSR_PIXEL_FORMAT, 32'(fmt));
      write_reg(bpr_pkg::CSR_RED_MASK, rm);
      write_reg(bpr_pkg::CSR_GREEN_MASK, gm);
      write_reg(bpr_pkg::CSR_BLUE_MASK, bm);
      write_reg(bpr_pkg::CSR_PAL_LIMIT, 32'(cnt));
      csr_valid <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      settings++;
   endtask

   task automatic test_reset_defaults();
      send_pixel(32'h0000_0000, 3'd0);
      send_pixel(32'hFFFF_FFFF, 3'd7);
      send_pixel(32'h0080_6040, 3'd3);
   endtask

   task automatic test_true_color();
      set_mode(bpr_pkg::FMT_24BPP, DEF_RED_MASK, DEF_GREEN_MASK, DEF_BLUE_MASK, 9'd256);
      send_pixel(32'h0000_0000, 3'd0);
      send_pixel(32'hFFFF_FFFF, 3'd5);
      send_pixel(32'hA1B2_C3D4, 3'd2);
   endtask

   task automatic test_masked_16();
      set_mode(bpr_pkg::FMT_16BPP, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 9'd256);
      send_pixel(32'h0000_0000, 3'd0);
      send_pixel(32'h0000_FFFF, 3'd1);
      send_pixel(32'hFFFF_0000, 3'd2);
      send_pixel(32'h1234_ABCD, 3'd3);
   endtask

   // full-width red, empty green, gapped blue
   task automatic test_odd_masks();
      set_mode(bpr_pkg::FMT_32BPP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_F0F0, 9'd256);
      send_pixel(32'hFFFF_FFFF, 3'd0);
      send_pixel(32'h0000_0000, 3'd4);
      send_pixel(32'h0F0F_5A5A, 3'd6);
   endtask

   task automatic test_indexed();
      push_item(bpr_pkg::FUNC_PALETTE, $urandom, 3'($urandom), 8'd0, 24'hFF_FFFF);
      push_item(bpr_pkg::FUNC_PALETTE, $urandom, 3'($urandom), 8'd1, 24'h5A_5A5A);
      push_item(bpr_pkg::FUNC_PALETTE, $urandom, 3'($urandom), 8'd2, 24'h00_0000);
      push_item(bpr_pkg::FUNC_PALETTE, $urandom, 3'($urandom), 8'd15, 24'hC3_C3C3);
      push_item(bpr_pkg::FUNC_PALETTE, $urandom, 3'($urandom), 8'd255, 24'h80_FF01);
      set_mode(bpr_pkg::FMT_8BPP, DEF_RED_MASK, DEF_GREEN_MASK, DEF_BLUE_MASK, 9'd256);
      send_pixel(32'h0000_00FF, 3'd0);
      send_pixel(32'hFFFF_FF00, 3'd7);
      set_mode(bpr_pkg::FMT_4BPP, DEF_RED_MASK, DEF_GREEN_MASK, DEF_BLUE_MASK, 9'd16);
      send_pixel(32'h0000_00F1, 3'd0);
      send_pixel(32'h0000_00F1, 3'd1);
      set_mode(bpr_pkg::FMT_1BPP, DEF_RED_MASK, DEF_GREEN_MASK, DEF_BLUE_MASK, 9'd2);
      send_pixel(32'h0000_0080, 3'd0);
      send_pixel(32'h0000_0080, 3'd7);
      send_pixel(32'h0000_0001, 3'd7);
      // index past the valid count reads as black
      set_mode(bpr_pkg::FMT_8BPP, DEF_RED_MASK, DEF_GREEN_MASK, DEF_BLUE_MASK, 9'd1);
      send_pixel(32'h0000_0001, 3'd0);
      send_pixel(32'h0000_0000, 3'd0);
      set_mode(bpr_pkg::FMT_8BPP, DEF_RED_MASK, DEF_GREEN_MASK, DEF_BLUE_MASK, 9'd0);
      send_pixel(32'h0000_0000, 3'd0);
   endtask

   task automatic test_unused_formats();
      set_mode(3'd6, DEF_RED_MASK, DEF_GREEN_MASK, DEF_BLUE_MASK, 9'd256);
      send_pixel(32'hFFFF_FFFF, 3'd0);
      set_mode(3'd7, DEF_RED_MASK, DEF_GREEN_MASK, DEF_BLUE_MASK, 9'd256);
      send_pixel(32'h1234_5678, 3'd3);
   endtask

   task automatic test_random_settings();
      logic [2:0] fmt;
      logic [8:0] cnt;
      repeat (10) begin
         fmt = ($urandom_range(0, 19) < 18) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
         case ($urandom_range(0, 7))
            0: cnt = 9'd1;
            1: cnt = 9'd256;
            2: cnt = 9'd2;
            3: cnt = 9'd16;
            4: cnt = ($urandom_range(0, 3) == 0) ? 9'd0 : 9'd255;
            default: cnt = 9'($urandom_range(1, 256));
         endcase
         set_mode(fmt, random_mask(), random_mask(), random_mask(), cnt);
         repeat (24) begin
            if ($urandom_range(0, 4) == 0)
               push_item(bpr_pkg::FUNC_PALETTE, $urandom, 3'($urandom),
                         $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                         24'($urandom));
            else
               send_pixel($urandom, 3'($urandom));
         end
      end
   endtask

   task automatic test_full_rate();
      set_mode(bpr_pkg::FMT_32BPP, random_mask(), random_mask(), random_mask(), 9'd256);
      steady <= 1'b1;
      repeat (40) send_pixel($urandom, 3'($urandom));
      quiesce();
      steady <= 1'b0;
   endtask

   // receiver stalls long enough for the pipeline and skid to fill
   task automatic test_backpressure();
      set_mode(bpr_pkg::FMT_16BPP, 32'h0000_7C00, 32'h0000_03E0, 32'h0000_001F, 9'd256);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      repeat (70) send_pixel($urandom, 3'($urandom));
   endtask

   task automatic test_drain_pause();
      set_mode(bpr_pkg::FMT_4BPP, DEF_RED_MASK, DEF_GREEN_MASK, DEF_BLUE_MASK, 9'd16);
      repeat (20) send_pixel($urandom, 3'($urandom));
      req_valid <= 1'b0;
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (20) send_pixel($urandom, 3'($urandom));
   endtask

   initial begin
      foreach (loaded[i]) loaded[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_true_color();
      test_masked_16();
      test_odd_masks();
      test_indexed();
      test_unused_formats();
      test_random_settings();
      test_full_rate();
      test_backpressure();
      test_drain_pause();
      quiesce();
      $display("Checked %0d conversions and %0d palette loads across %0d register settings,",
               conversions, palette_loads, settings);
      $display("covering all pixel formats, edge masks, palette limits and output stalls.");
      if (mismatch_count == 0) begin
         $display("bitmap_pixel_to_rgb_converter_top verification clean");
      end else begin
         $display("bitmap_pixel_to_rgb_converter_top verification failed");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 13);
      end
   end

   always @(posedge clock) begin : check_rsp
      pixel_rgb_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rgb.size() == 0) begin
            $error("unexpected transfer: red %0d green %0d blue %0d",
                   rsp_red, rsp_green, rsp_blue);
            mismatch_count++;
         end else begin
            want = pending_rgb.pop_front();
            if (rsp_red !== want.red) begin
               $error("red: expected %0d, actual %0d", want.red, rsp_red);
               mismatch_count++;
            end
            if (rsp_green !== want.green) begin
               $error("green: expected %0d, actual %0d", want.green, rsp_green);
               mismatch_count++;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue: expected %0d, actual %0d", want.blue, rsp_blue);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("bitmap_pixel_to_rgb_converter_top verification failed");
         $finish;
      end
   end

endmodule
